@@ hw/rtl/i2c_bit_level_master_macros.svh @@
// Assertion helpers for the RTL that checks itself.
`ifndef I2C_BIT_LEVEL_MASTER_MACROS_SVH
`define I2C_BIT_LEVEL_MASTER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define I2CBLM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define I2CBLM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/i2cblm_pkg.sv @@
package i2cblm_pkg;

    // Width of the phase tick counter.
    localparam int unsigned DIVIDER_WIDTH = 16;

    localparam int unsigned HALF_PERIOD_W  = 16;
    localparam int unsigned POLL_W         = 8;
    localparam int unsigned CFG_IDX_W      = 8;
    localparam int unsigned CFG_DATA_W     = 16;

    localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RST    = 16'd20;
    localparam logic [POLL_W-1:0]        ACK_POLL_LIMIT_RST = 8'd20;
    localparam logic [3:0]               BITS_PER_BYTE      = 4'd8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_POLL_LIMIT = 8'd1;

    // Command codes.
    localparam logic [2:0] CMD_START     = 3'd0;
    localparam logic [2:0] CMD_STOP      = 3'd1;
    localparam logic [2:0] CMD_WRITE     = 3'd2;
    localparam logic [2:0] CMD_READ_ACK  = 3'd3;
    localparam logic [2:0] CMD_READ_NACK = 3'd4;
    localparam logic [2:0] CMD_READ_ONLY = 3'd5;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_ST_A    = 4'd1,
        PH_ST_B    = 4'd2,
        PH_SP_A    = 4'd3,
        PH_SP_B    = 4'd4,
        PH_WR_LO   = 4'd5,
        PH_WR_HI   = 4'd6,
        PH_WA_LO   = 4'd7,
        PH_WA_POLL = 4'd8,
        PH_RD_LO   = 4'd9,
        PH_RD_HI   = 4'd10,
        PH_N_LO    = 4'd11,
        PH_N_HI    = 4'd12,
        PH_N_TAIL  = 4'd13
    } t_phase;

endpackage

@@ hw/rtl/i2cblm_intf.sv @@
// Tick channel into the sequencer.
interface i2cblm_in_if;
    logic       valid;
    logic       ready;
    logic       cmd_valid;
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       sda_in;

    modport source (output valid, cmd_valid, command, tx_byte, sda_in, input ready);
    modport sink   (input valid, cmd_valid, command, tx_byte, sda_in, output ready);
endinterface

// Bus levels and status after each tick.
interface i2cblm_out_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic       ack_seen;
    logic [7:0] rx_byte;

    modport source (output valid, scl_out, sda_out, sda_drive, busy_res, done_res,
                    ack_seen, rx_byte, input ready);
    modport sink   (input valid, scl_out, sda_out, sda_drive, busy_res, done_res,
                    ack_seen, rx_byte, output ready);
endinterface

// Register write channel.
interface i2cblm_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/i2c_bit_level_master.sv @@
// Channel   Direction  Carries
// i_in      in         one timing tick: cmd_valid, command, tx_byte, sda_in
// o_out     out        bus levels and status after that tick
// i_cfg     in         register writes: 0 half_period, 1 ack_poll_limit
//
// One request is taken every clock cycle unless the output stalls; its result
// is ready in the next cycle. The sequencer state and the result register update
// in the same edge, so the only limit on rate is the single output register.
// Reset (i_rst_n low at a clock edge) puts the sequencer idle with SCL high and
// SDA released, and loads the register defaults (20 and 20).
// When the result is not taken, i_in.ready drops and no further tick is consumed.
// Register writes are always accepted.

`include "i2c_bit_level_master_macros.svh"

module i2c_bit_level_master
    import i2cblm_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    i2cblm_in_if.sink     i_in,
    i2cblm_out_if.source  o_out,
    i2cblm_cfg_if.sink    i_cfg
);

    // Configuration registers.
    logic [HALF_PERIOD_W-1:0] r_half_period;
    logic [POLL_W-1:0]        r_ack_poll_limit;

    // Sequencer state.
    t_phase                   r_phase,    n_phase;
    logic [2:0]               r_cmd,      n_cmd;
    logic [3:0]               r_bits,     n_bits;
    logic [7:0]               r_shift,    n_shift;
    logic [DIVIDER_WIDTH-1:0] r_tick,     n_tick;
    logic [POLL_W-1:0]        r_poll,     n_poll;
    logic                     r_ack,      n_ack;
    logic [7:0]               r_rx,       n_rx;
    logic                     r_scl,      n_scl;
    logic                     r_sda_lvl,  n_sda_lvl;
    logic                     r_sda_en,   n_sda_en;
    logic                     n_done;

    // Result register.
    logic                     r_out_valid;
    logic                     r_out_done;

    logic                     in_accept;
    logic [DIVIDER_WIDTH-1:0] tick_inc;
    logic                     phase_over;
    logic [7:0]               shift_wr;
    logic [7:0]               shift_rd;
    logic [3:0]               bits_inc;

    // The result register is free when empty or being drained this cycle.
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_accept   = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period    <= HALF_PERIOD_RST;
            r_ack_poll_limit <= ACK_POLL_LIMIT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_HALF_PERIOD:    r_half_period    <= i_cfg.data;
                CFG_ACK_POLL_LIMIT: r_ack_poll_limit <= i_cfg.data[POLL_W-1:0];
                default: ;
            endcase
        end
    end

    // A timed phase ends when the counter reaches the half period or would wrap.
    // A zero half period therefore behaves like one.
    assign tick_inc   = r_tick + 1'b1;
    assign phase_over = (tick_inc == '0) ||
                        (32'(tick_inc) >= 32'(r_half_period));
    assign shift_wr   = {r_shift[6:0], 1'b0};
    assign shift_rd   = {r_shift[6:0], i_in.sda_in};
    assign bits_inc   = r_bits + 1'b1;

    always_comb begin
        n_phase   = r_phase;
        n_cmd     = r_cmd;
        n_bits    = r_bits;
        n_shift   = r_shift;
        n_tick    = r_tick;
        n_poll    = r_poll;
        n_ack     = r_ack;
        n_rx      = r_rx;
        n_scl     = r_scl;
        n_sda_lvl = r_sda_lvl;
        n_sda_en  = r_sda_en;
        n_done    = 1'b0;

        if (r_phase == PH_IDLE || r_phase > PH_N_TAIL) begin
            // Idle: take a command; undefined codes start nothing.
            n_phase = PH_IDLE;
            if (i_in.cmd_valid && i_in.command <= CMD_READ_ONLY) begin
                n_cmd  = i_in.command;
                n_bits = '0;
                n_tick = '0;
                case (i_in.command)
                    CMD_START: begin
                        n_phase = PH_ST_A;
                        {n_scl, n_sda_en, n_sda_lvl} = 3'b111;
                    end
                    CMD_STOP: begin
                        n_phase = PH_SP_A;
                        {n_scl, n_sda_en, n_sda_lvl} = 3'b010;
                    end
                    CMD_WRITE: begin
                        n_shift   = i_in.tx_byte;
                        n_ack     = 1'b0;
                        n_phase   = PH_WR_LO;
                        n_scl     = 1'b0;
                        n_sda_en  = 1'b1;
                        n_sda_lvl = i_in.tx_byte[7];
                    end
                    default: begin
                        n_shift = '0;
                        n_phase = PH_RD_LO;
                        {n_scl, n_sda_en, n_sda_lvl} = 3'b001;
                    end
                endcase
            end
        end else if (r_phase == PH_WA_POLL) begin
            // Acknowledge poll: one SDA sample per tick.
            if (!i_in.sda_in || r_poll >= r_ack_poll_limit) begin
                n_ack   = !i_in.sda_in;
                n_phase = PH_IDLE;
                n_tick  = '0;
                n_done  = 1'b1;
                {n_scl, n_sda_en, n_sda_lvl} = 3'b001;
            end else begin
                n_poll = r_poll + 1'b1;
            end
        end else if (!phase_over) begin
            n_tick = tick_inc;
        end else begin
            n_tick = '0;
            case (r_phase)
                PH_ST_A: begin
                    n_phase = PH_ST_B;
                    {n_scl, n_sda_en, n_sda_lvl} = 3'b110;
                end
                PH_ST_B: begin
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                    {n_scl, n_sda_en, n_sda_lvl} = 3'b010;
                end
                PH_SP_A: begin
                    n_phase = PH_SP_B;
                    {n_scl, n_sda_en, n_sda_lvl} = 3'b110;
                end
                PH_SP_B: begin
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                    {n_scl, n_sda_en, n_sda_lvl} = 3'b111;
                end
                PH_WR_LO: begin
                    n_phase = PH_WR_HI;
                    n_scl   = 1'b1;
                end
                PH_WR_HI: begin
                    // Next data bit changes at the start of the low phase.
                    n_shift = shift_wr;
                    n_bits  = bits_inc;
                    if (bits_inc >= BITS_PER_BYTE) begin
                        n_phase = PH_WA_LO;
                        {n_scl, n_sda_en, n_sda_lvl} = 3'b001;
                    end else begin
                        n_phase   = PH_WR_LO;
                        n_scl     = 1'b0;
                        n_sda_en  = 1'b1;
                        n_sda_lvl = shift_wr[7];
                    end
                end
                PH_WA_LO: begin
                    n_phase = PH_WA_POLL;
                    n_poll  = '0;
                    {n_scl, n_sda_en, n_sda_lvl} = 3'b101;
                end
                PH_RD_LO: begin
                    n_phase = PH_RD_HI;
                    {n_scl, n_sda_en, n_sda_lvl} = 3'b101;
                end
                PH_RD_HI: begin
                    // Sample on the last tick of the high phase.
                    n_shift = shift_rd;
                    n_bits  = bits_inc;
                    if (bits_inc >= BITS_PER_BYTE) begin
                        n_rx = shift_rd;
                        if (r_cmd == CMD_READ_ACK) begin
                            n_phase = PH_N_LO;
                            {n_scl, n_sda_en, n_sda_lvl} = 3'b010;
                        end else if (r_cmd == CMD_READ_NACK) begin
                            n_phase = PH_N_LO;
                            {n_scl, n_sda_en, n_sda_lvl} = 3'b001;
                        end else begin
                            // Read only: hold SCL low with SDA driven low.
                            n_phase = PH_IDLE;
                            n_done  = 1'b1;
                            {n_scl, n_sda_en, n_sda_lvl} = 3'b010;
                        end
                    end else begin
                        n_phase = PH_RD_LO;
                        {n_scl, n_sda_en, n_sda_lvl} = 3'b001;
                    end
                end
                PH_N_LO: begin
                    n_phase = PH_N_HI;
                    n_scl   = 1'b1;
                end
                PH_N_HI: begin
                    n_scl = 1'b0;
                    if (r_cmd == CMD_READ_ACK) begin
                        // Keep SDA low for one more low half period.
                        n_phase = PH_N_TAIL;
                    end else begin
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end
                end
                PH_N_TAIL: begin
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                    {n_scl, n_sda_en, n_sda_lvl} = 3'b001;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_cmd       <= '0;
            r_bits      <= '0;
            r_shift     <= '0;
            r_tick      <= '0;
            r_poll      <= '0;
            r_ack       <= 1'b0;
            r_rx        <= '0;
            r_scl       <= 1'b1;
            r_sda_lvl   <= 1'b1;
            r_sda_en    <= 1'b0;
            r_out_done  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_phase    <= n_phase;
                r_cmd      <= n_cmd;
                r_bits     <= n_bits;
                r_shift    <= n_shift;
                r_tick     <= n_tick;
                r_poll     <= n_poll;
                r_ack      <= n_ack;
                r_rx       <= n_rx;
                r_scl      <= n_scl;
                r_sda_lvl  <= n_sda_lvl;
                r_sda_en   <= n_sda_en;
                r_out_done <= n_done;
            end
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The result of a tick is the state it leaves, so it reads straight from
    // the sequencer registers, which hold while the result waits.
    assign o_out.valid     = r_out_valid;
    assign o_out.scl_out   = r_scl;
    assign o_out.sda_out   = r_sda_lvl;
    assign o_out.sda_drive = r_sda_en;
    assign o_out.busy_res  = (r_phase != PH_IDLE);
    assign o_out.done_res  = r_out_done;
    assign o_out.ack_seen  = r_ack;
    assign o_out.rx_byte   = r_rx;

    `I2CBLM_ASSERT_NOW(a_released_sda_high, i_clk, i_rst_n, !r_sda_en, r_sda_lvl, "released SDA must read high")
    `I2CBLM_ASSERT_NOW(a_done_means_idle, i_clk, i_rst_n, r_out_done, r_phase == PH_IDLE, "done while still busy")
    `I2CBLM_ASSERT_NEXT(a_accept_gives_result, i_clk, i_rst_n, in_accept, r_out_valid, "accepted tick gave no result")
    `I2CBLM_ASSERT_NOW(a_stall_blocks_input, i_clk, i_rst_n, r_out_valid && !o_out.ready, !i_in.ready, "tick taken while result stalled")

endmodule

@@ test/testbench.sv @@
// Testbench for the tick-driven I2C bit-level master.
//
// Every request on the input channel is one timing tick of the sequencer, and
// every tick gives back exactly one result: the bus levels and the status after
// that tick. The bench keeps its own model of the sequencer. Each accepted
// request is run through that model right away, and the predicted levels are
// queued. A separate process compares every result that leaves the block with
// the oldest queued prediction, field by field.
//
// Commands are played out tick by tick. The bench keeps sending ticks until its
// model says the sequencer is idle again. While a command runs, the command
// fields carry random noise, because the block must ignore new commands when it
// is busy. SDA is driven as a slave would drive it: during the ACK poll it goes
// low after a chosen number of samples, or never, and during a read it carries
// the bits of a chosen byte for the whole SCL high phase.

module testbench;
    import i2cblm_pkg::*;

    // Codes that the block must ignore.
    localparam logic [2:0] CMD_UNDEF_6 = 3'd6;
    localparam logic [2:0] CMD_UNDEF_7 = 3'd7;
    // A register index that does not exist.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'd2;

    // The limit lies well above the length of a correct run, stalls and gaps included.
    localparam int CYCLE_LIMIT = 100000;
    localparam int RANDOM_WORK_TICKS = 300;
    // An ACK delay larger than any poll window: the slave never answers.
    localparam int NO_ACK = 1000;

    typedef struct {
        logic       cmd_valid;
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic       sda_in;
    } t_tick;

    typedef struct {
        logic       scl;
        logic       sda;
        logic       sda_drive;
        logic       busy;
        logic       done;
        logic       ack;
        logic [7:0] rx;
    } t_levels;

    logic i_clk = 1'b0;
    logic i_rst_n;

    i2cblm_in_if  in_bus();
    i2cblm_out_if out_bus();
    i2cblm_cfg_if cfg_bus();

    i2c_bit_level_master uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    // Predicted bus levels, oldest first.
    t_levels expected_levels[$];

    int mismatch_count = 0;
    int cycle_count = 0;
    int work_ticks = 0;

    // When quiet is set neither side idles. Calm stretches come and go at random.
    logic quiet = 1'b0;
    logic calm = 1'b0;

    // Configuration as the model sees it.
    logic [HALF_PERIOD_W-1:0] half_period_reg;
    logic [POLL_W-1:0]        ack_poll_limit_reg;

    // Sequencer state as the model sees it.
    t_phase                   seq_phase;
    logic [2:0]               seq_cmd;
    logic [3:0]               seq_bits;
    logic [7:0]               seq_shift;
    logic [DIVIDER_WIDTH-1:0] seq_ticks;
    logic [POLL_W-1:0]        seq_polls;
    logic                     seq_ack;
    logic [7:0]               seq_rx;
    logic                     lvl_scl;
    logic                     lvl_sda;
    logic                     lvl_drive;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Model of the sequencer
    // ------------------------------------------------------------------

    function automatic void set_lines(logic scl, logic drive_en, logic level);
        lvl_scl = scl;
        lvl_drive = drive_en;
        // A released line reads high through the pull-up.
        lvl_sda = drive_en ? level : 1'b1;
    endfunction

    function automatic void enter_phase(t_phase next_phase);
        seq_phase = next_phase;
        seq_ticks = '0;
    endfunction

    // Advances the phase timer. A phase ends after half_period ticks, or after
    // one tick when the half period is zero, or when the counter would wrap.
    function automatic logic phase_timer_expired();
        logic [DIVIDER_WIDTH-1:0] next_ticks;
        next_ticks = seq_ticks + 1'b1;
        if (next_ticks == '0 || next_ticks >= half_period_reg) begin
            seq_ticks = '0;
            return 1'b1;
        end
        seq_ticks = next_ticks;
        return 1'b0;
    endfunction

    function automatic void reset_sequencer_model();
        half_period_reg = HALF_PERIOD_RST;
        ack_poll_limit_reg = ACK_POLL_LIMIT_RST;
        seq_phase = PH_IDLE;
        seq_cmd = CMD_START;
        seq_bits = '0;
        seq_shift = '0;
        seq_ticks = '0;
        seq_polls = '0;
        seq_ack = 1'b0;
        seq_rx = '0;
        set_lines(1'b1, 1'b0, 1'b1);
    endfunction

    function automatic void apply_register_write(logic [CFG_IDX_W-1:0] idx,
                                                 logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_HALF_PERIOD:    half_period_reg = data[HALF_PERIOD_W-1:0];
            CFG_ACK_POLL_LIMIT: ack_poll_limit_reg = data[POLL_W-1:0];
            default: ;
        endcase
    endfunction

    // Runs one tick through the model and returns the levels after it.
    function automatic t_levels predict_bus_levels(t_tick tk);
        t_levels r;
        logic done_now;
        logic poll_over;
        done_now = 1'b0;
        poll_over = 1'b0;

        if (seq_phase == PH_IDLE) begin
            if (tk.cmd_valid && tk.command <= CMD_READ_ONLY) begin
                seq_cmd = tk.command;
                seq_bits = '0;
                case (tk.command)
                    CMD_START: begin
                        enter_phase(PH_ST_A);
                        set_lines(1'b1, 1'b1, 1'b1);
                    end
                    CMD_STOP: begin
                        enter_phase(PH_SP_A);
                        set_lines(1'b0, 1'b1, 1'b0);
                    end
                    CMD_WRITE: begin
                        seq_shift = tk.tx_byte;
                        seq_ack = 1'b0;
                        enter_phase(PH_WR_LO);
                        set_lines(1'b0, 1'b1, seq_shift[7]);
                    end
                    default: begin
                        seq_shift = '0;
                        enter_phase(PH_RD_LO);
                        set_lines(1'b0, 1'b0, 1'b1);
                    end
                endcase
            end
        end else if (seq_phase == PH_WA_POLL) begin
            // SDA is sampled every tick; a low level is the slave's ACK.
            if (!tk.sda_in) begin
                seq_ack = 1'b1;
                poll_over = 1'b1;
            end else if (seq_polls >= ack_poll_limit_reg) begin
                seq_ack = 1'b0;
                poll_over = 1'b1;
            end else begin
                seq_polls = seq_polls + 1'b1;
            end
            if (poll_over) begin
                set_lines(1'b0, 1'b0, 1'b1);
                enter_phase(PH_IDLE);
                done_now = 1'b1;
            end
        end else if (phase_timer_expired()) begin
            case (seq_phase)
                PH_ST_A: begin
                    enter_phase(PH_ST_B);
                    set_lines(1'b1, 1'b1, 1'b0);
                end
                PH_ST_B: begin
                    set_lines(1'b0, 1'b1, 1'b0);
                    enter_phase(PH_IDLE);
                    done_now = 1'b1;
                end
                PH_SP_A: begin
                    enter_phase(PH_SP_B);
                    set_lines(1'b1, 1'b1, 1'b0);
                end
                PH_SP_B: begin
                    set_lines(1'b1, 1'b1, 1'b1);
                    enter_phase(PH_IDLE);
                    done_now = 1'b1;
                end
                PH_WR_LO: begin
                    enter_phase(PH_WR_HI);
                    lvl_scl = 1'b1;
                end
                PH_WR_HI: begin
                    // The next data bit is set up as SCL falls.
                    seq_shift = {seq_shift[6:0], 1'b0};
                    seq_bits = seq_bits + 1'b1;
                    if (seq_bits >= BITS_PER_BYTE) begin
                        enter_phase(PH_WA_LO);
                        set_lines(1'b0, 1'b0, 1'b1);
                    end else begin
                        enter_phase(PH_WR_LO);
                        set_lines(1'b0, 1'b1, seq_shift[7]);
                    end
                end
                PH_WA_LO: begin
                    enter_phase(PH_WA_POLL);
                    seq_polls = '0;
                    set_lines(1'b1, 1'b0, 1'b1);
                end
                PH_RD_LO: begin
                    enter_phase(PH_RD_HI);
                    set_lines(1'b1, 1'b0, 1'b1);
                end
                PH_RD_HI: begin
                    // The bit is taken on the last tick of the SCL high phase.
                    seq_shift = {seq_shift[6:0], tk.sda_in};
                    seq_bits = seq_bits + 1'b1;
                    if (seq_bits >= BITS_PER_BYTE) begin
                        seq_rx = seq_shift;
                        if (seq_cmd == CMD_READ_ACK) begin
                            enter_phase(PH_N_LO);
                            set_lines(1'b0, 1'b1, 1'b0);
                        end else if (seq_cmd == CMD_READ_NACK) begin
                            enter_phase(PH_N_LO);
                            set_lines(1'b0, 1'b0, 1'b1);
                        end else begin
                            // A read without the acknowledge clock parks SCL low, SDA low.
                            set_lines(1'b0, 1'b1, 1'b0);
                            enter_phase(PH_IDLE);
                            done_now = 1'b1;
                        end
                    end else begin
                        enter_phase(PH_RD_LO);
                        set_lines(1'b0, 1'b0, 1'b1);
                    end
                end
                PH_N_LO: begin
                    enter_phase(PH_N_HI);
                    lvl_scl = 1'b1;
                end
                PH_N_HI: begin
                    lvl_scl = 1'b0;
                    // After an ACK, SDA stays low for one more low half period.
                    if (seq_cmd == CMD_READ_ACK) begin
                        enter_phase(PH_N_TAIL);
                    end else begin
                        enter_phase(PH_IDLE);
                        done_now = 1'b1;
                    end
                end
                PH_N_TAIL: begin
                    set_lines(1'b0, 1'b0, 1'b1);
                    enter_phase(PH_IDLE);
                    done_now = 1'b1;
                end
                default: ;
            endcase
        end

        r.scl = lvl_scl;
        r.sda = lvl_sda;
        r.sda_drive = lvl_drive;
        r.busy = (seq_phase != PH_IDLE);
        r.done = done_now;
        r.ack = seq_ack;
        r.rx = seq_rx;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, int exp_val, int got_val);
        $display("mismatch at cycle %0d: %s expected %0h got %0h",
                 cycle_count, what, exp_val, got_val);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_levels want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (expected_levels.size() == 0) begin
                report_mismatch("result with no request pending", 0, 1);
            end else begin
                want = expected_levels.pop_front();
                if (out_bus.scl_out !== want.scl)
                    report_mismatch("scl_out", want.scl, out_bus.scl_out);
                if (out_bus.sda_out !== want.sda)
                    report_mismatch("sda_out", want.sda, out_bus.sda_out);
                if (out_bus.sda_drive !== want.sda_drive)
                    report_mismatch("sda_drive", want.sda_drive, out_bus.sda_drive);
                if (out_bus.busy_res !== want.busy)
                    report_mismatch("busy_res", want.busy, out_bus.busy_res);
                if (out_bus.done_res !== want.done)
                    report_mismatch("done_res", want.done, out_bus.done_res);
                if (out_bus.ack_seen !== want.ack)
                    report_mismatch("ack_seen", want.ack, out_bus.ack_seen);
                if (out_bus.rx_byte !== want.rx)
                    report_mismatch("rx_byte", want.rx, out_bus.rx_byte);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stall bursts, and calm stretches for both sides
    // ------------------------------------------------------------------

    initial begin
        int stall_left;
        int mode_left;
        stall_left = 0;
        mode_left = 0;
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                calm = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(100, 400);
            end else begin
                mode_left--;
            end
            if (quiet || calm) begin
                stall_left = 0;
                out_bus.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_bus.ready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 10) - 1;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offers one tick, waits for it to be taken, and queues its prediction.
    // Valid is left high after the handshake so that back-to-back ticks go out
    // without a bubble; a gap in the next call or a drain lowers it.
    task automatic send_tick(t_tick tk);
        int gap;
        t_levels pred;
        gap = 0;
        if (!quiet && !calm && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 10);
        repeat (gap) begin
            @(negedge i_clk);
            in_bus.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_bus.valid <= 1'b1;
        in_bus.cmd_valid <= tk.cmd_valid;
        in_bus.command <= tk.command;
        in_bus.tx_byte <= tk.tx_byte;
        in_bus.sda_in <= tk.sda_in;
        do @(posedge i_clk); while (!in_bus.ready);
        pred = predict_bus_levels(tk);
        expected_levels.push_back(pred);
        if (pred.busy || pred.done)
            work_ticks++;
    endtask

    // Stops sending and waits until every predicted result has been checked,
    // then lets the output register go idle.
    task automatic wait_drained();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (expected_levels.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Register writes go in only while the sequencer is idle and drained.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_drained();
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        apply_register_write(idx, data);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic send_idle_ticks(int count);
        t_tick tk;
        repeat (count) begin
            tk.cmd_valid = 1'b0;
            tk.command = $urandom_range(0, 7);
            tk.tx_byte = $urandom_range(0, 255);
            tk.sda_in = $urandom_range(0, 1);
            send_tick(tk);
        end
    endtask

    // Issues one command and keeps ticking until the model is idle again.
    // The slave answers the ACK poll after ack_delay high samples and offers
    // rx_pattern, MSB first, during reads.
    task automatic run_command(logic [2:0] cmd, logic [7:0] tx, logic [7:0] rx_pattern,
                               int ack_delay);
        t_tick tk;
        int polls_seen;
        polls_seen = 0;
        tk.cmd_valid = 1'b1;
        tk.command = cmd;
        tk.tx_byte = tx;
        tk.sda_in = $urandom_range(0, 1);
        send_tick(tk);
        while (seq_phase != PH_IDLE) begin
            // Commands offered while busy are noise that must be ignored.
            tk.cmd_valid = $urandom_range(0, 1);
            tk.command = $urandom_range(0, 7);
            tk.tx_byte = $urandom_range(0, 255);
            if (seq_phase == PH_WA_POLL) begin
                tk.sda_in = (polls_seen >= ack_delay) ? 1'b0 : 1'b1;
                polls_seen++;
            end else if (seq_phase == PH_RD_HI) begin
                tk.sda_in = rx_pattern[3'd7 - seq_bits[2:0]];
            end else begin
                tk.sda_in = $urandom_range(0, 1);
            end
            send_tick(tk);
        end
    endtask

    // Picks when the slave acknowledges: soon, anywhere in the window or just past it,
    // exactly on the last sample, or never.
    function automatic int pick_ack_delay();
        case ($urandom_range(0, 5))
            0: return NO_ACK;
            1: return ack_poll_limit_reg;
            2: return $urandom_range(0, ack_poll_limit_reg + 1);
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    function automatic logic [2:0] pick_data_command();
        case ($urandom_range(0, 3))
            0: return CMD_READ_ACK;
            1: return CMD_READ_NACK;
            2: return CMD_READ_ONLY;
            default: return CMD_WRITE;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset the registers hold 20 and 20; a START and a STOP at that
    // speed show the default half period.
    task automatic test_reset_defaults();
        send_idle_ticks(3);
        run_command(CMD_START, 8'h00, 8'h00, 0);
        run_command(CMD_STOP, 8'h00, 8'h00, 0);
    endtask

    // Every command at least once at the fastest useful speed, plus the two undefined
    // codes, which must not start anything.
    task automatic test_every_command();
        write_register(CFG_HALF_PERIOD, 16'd1);
        write_register(CFG_ACK_POLL_LIMIT, 16'd3);
        run_command(CMD_START, 8'h00, 8'h00, 0);
        run_command(CMD_WRITE, 8'hA5, 8'h00, 0);
        run_command(CMD_WRITE, 8'h00, 8'h00, 2);
        run_command(CMD_WRITE, 8'hFF, 8'h00, NO_ACK);
        run_command(CMD_READ_ACK, 8'h00, 8'hFF, 0);
        run_command(CMD_READ_NACK, 8'h00, 8'h00, 0);
        run_command(CMD_READ_ONLY, 8'h00, 8'h5A, 0);
        run_command(CMD_STOP, 8'h00, 8'h00, 0);
        run_command(CMD_UNDEF_6, 8'hFF, 8'h00, 0);
        run_command(CMD_UNDEF_7, 8'h00, 8'h00, 0);
        send_idle_ticks(2);
    endtask

    // A zero half period must behave like a half period of one tick.
    task automatic test_zero_half_period();
        write_register(CFG_HALF_PERIOD, 16'd0);
        run_command(CMD_START, 8'h00, 8'h00, 0);
        run_command(CMD_WRITE, 8'h81, 8'h00, 1);
        run_command(CMD_READ_ACK, 8'h00, 8'h3C, 0);
        run_command(CMD_STOP, 8'h00, 8'h00, 0);
    endtask

    // Both ends of the ACK poll window: a one-sample window answered and not
    // answered, and the widest window left unanswered to its last sample.
    task automatic test_ack_poll_extremes();
        write_register(CFG_HALF_PERIOD, 16'd2);
        write_register(CFG_ACK_POLL_LIMIT, 16'd0);
        run_command(CMD_WRITE, 8'h7E, 8'h00, 0);
        run_command(CMD_WRITE, 8'h01, 8'h00, NO_ACK);
        write_register(CFG_ACK_POLL_LIMIT, 16'd255);
        run_command(CMD_WRITE, 8'hC3, 8'h00, NO_ACK);
    endtask

    // A write to a missing index changes nothing, and only the low byte of the
    // poll limit write counts. A write with no ACK shows the resulting window.
    task automatic test_register_writes();
        write_register(CFG_UNUSED_IDX, 16'hFFFF);
        write_register(CFG_ACK_POLL_LIMIT, 16'hFF02);
        write_register(CFG_HALF_PERIOD, 16'd3);
        run_command(CMD_WRITE, 8'h55, 8'h00, NO_ACK);
        run_command(CMD_READ_NACK, 8'h00, 8'hA5, 0);
    endtask

    // Random transactions: mostly START, a few data bytes and STOP, with now
    // and then a lone random command, an undefined code or quiet ticks. The
    // settings change between transactions, mostly to short half periods.
    task automatic test_random_transactions();
        int work_goal;
        int n_data;
        logic [2:0] cmd;
        work_goal = work_ticks + RANDOM_WORK_TICKS;
        while (work_ticks < work_goal) begin
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 9))
                    0: write_register(CFG_HALF_PERIOD, $urandom_range(7, 24));
                    1: write_register(CFG_HALF_PERIOD, 16'd0);
                    2, 3: write_register(CFG_HALF_PERIOD, $urandom_range(3, 6));
                    default: write_register(CFG_HALF_PERIOD, $urandom_range(1, 2));
                endcase
                case ($urandom_range(0, 4))
                    0: write_register(CFG_ACK_POLL_LIMIT, $urandom_range(31, 255));
                    1, 2: write_register(CFG_ACK_POLL_LIMIT, $urandom_range(5, 30));
                    default: write_register(CFG_ACK_POLL_LIMIT, $urandom_range(0, 4));
                endcase
            end
            if ($urandom_range(0, 7) == 0) begin
                if ($urandom_range(0, 1) == 0) begin
                    send_idle_ticks($urandom_range(1, 5));
                end else begin
                    cmd = $urandom_range(0, 7);
                    run_command(cmd, $urandom_range(0, 255), $urandom_range(0, 255),
                                pick_ack_delay());
                end
            end else begin
                run_command(CMD_START, $urandom_range(0, 255), 8'h00, 0);
                n_data = $urandom_range(1, 3);
                repeat (n_data) begin
                    // Now and then a repeated start sits between the bytes.
                    if ($urandom_range(0, 5) == 0)
                        run_command(CMD_START, 8'h00, 8'h00, 0);
                    run_command(pick_data_command(), $urandom_range(0, 255),
                                $urandom_range(0, 255), pick_ack_delay());
                end
                run_command(CMD_STOP, $urandom_range(0, 255), 8'h00, 0);
            end
        end
    endtask

    // A long half period, with no idling on either side. One START shows the
    // counter running well past its low bits.
    task automatic test_longest_half_period();
        quiet = 1'b1;
        write_register(CFG_HALF_PERIOD, 16'd64);
        run_command(CMD_START, 8'h00, 8'h00, 0);
    endtask

    initial begin
        in_bus.valid = 1'b0;
        in_bus.cmd_valid = 1'b0;
        in_bus.command = CMD_START;
        in_bus.tx_byte = 8'h00;
        in_bus.sda_in = 1'b1;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = CFG_HALF_PERIOD;
        cfg_bus.data = '0;
        i_rst_n = 1'b0;
        reset_sequencer_model();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_every_command();
        test_zero_half_period();
        test_ack_poll_extremes();
        test_register_writes();
        test_random_transactions();
        test_longest_half_period();

        wait_drained();
        repeat (5) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ i2c_bit_level_master.f @@
+incdir+hw/rtl
hw/rtl/i2cblm_pkg.sv
hw/rtl/i2cblm_intf.sv
hw/rtl/i2c_bit_level_master.sv
test/testbench.sv
